// File: rtl/core/heading_distance_servo_unit_defines.svh
// Assertion macros shared by the heading and distance servo RTL.
`ifndef HEADING_DISTANCE_SERVO_UNIT_DEFINES_SVH
`define HEADING_DISTANCE_SERVO_UNIT_DEFINES_SVH

// Same-cycle implication checked on every rising clock edge outside reset.
`define HDS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heading_distance_servo_unit: same-cycle check failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define HDS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heading_distance_servo_unit: next-cycle check failed");

`endif

// File: rtl/core/hds_pkg.sv
// Types, constants and microprogram of the heading and distance servo.
package hds_pkg;

  localparam int unsigned PC_W = 3;

  typedef logic [PC_W-1:0] pc_t;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_SQ_A = 3'd1;
  localparam logic [2:0] OP_SQ_B = 3'd2;
  localparam logic [2:0] OP_SUM  = 3'd3;
  localparam logic [2:0] OP_ROOT = 3'd4;
  localparam logic [2:0] OP_ACC  = 3'd5;
  localparam logic [2:0] OP_OUT  = 3'd6;

  localparam logic [1:0] BR_NEXT = 2'd0;
  localparam logic [1:0] BR_LOOP = 2'd1;
  localparam logic [1:0] BR_JUMP = 2'd2;

  localparam pc_t STEP_LOAD = 3'd0;
  localparam pc_t STEP_SQ_A = 3'd1;
  localparam pc_t STEP_SQ_B = 3'd2;
  localparam pc_t STEP_SUM  = 3'd3;
  localparam pc_t STEP_ROOT = 3'd4;
  localparam pc_t STEP_ACC  = 3'd5;
  localparam pc_t STEP_OUT  = 3'd6;

  localparam logic [1:0] REG_GOAL_SPEED    = 2'd0;
  localparam logic [1:0] REG_GOAL_DISTANCE = 2'd1;
  localparam logic [1:0] REG_GOAL_HEADING  = 2'd2;

  localparam logic [31:0] MM_TO_UM = 32'd1000;

  localparam logic signed [17:0] HALF_TURN    = 18'sd32768;
  localparam logic signed [17:0] FULL_TURN    = 18'sd65536;
  localparam logic        [17:0] FAST_LIMIT   = 18'd3277;
  localparam logic signed [15:0] QUARTER_RATE = 16'sd16384;

  typedef struct packed {
    logic [2:0] op;
    logic       wait_in;
    logic       wait_out;
    logic [1:0] br;
    pc_t        target;
  } ctrl_t;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t cw;
    cw = '{op: OP_LOAD, wait_in: 1'b1, wait_out: 1'b0, br: BR_JUMP, target: STEP_LOAD};
    unique case (pc)
      STEP_LOAD: cw = '{op: OP_LOAD, wait_in: 1'b1, wait_out: 1'b0, br: BR_NEXT,
                        target: STEP_LOAD};
      STEP_SQ_A: cw = '{op: OP_SQ_A, wait_in: 1'b0, wait_out: 1'b0, br: BR_NEXT,
                        target: STEP_LOAD};
      STEP_SQ_B: cw = '{op: OP_SQ_B, wait_in: 1'b0, wait_out: 1'b0, br: BR_NEXT,
                        target: STEP_LOAD};
      STEP_SUM:  cw = '{op: OP_SUM, wait_in: 1'b0, wait_out: 1'b0, br: BR_NEXT,
                        target: STEP_LOAD};
      STEP_ROOT: cw = '{op: OP_ROOT, wait_in: 1'b0, wait_out: 1'b0, br: BR_LOOP,
                        target: STEP_ROOT};
      STEP_ACC:  cw = '{op: OP_ACC, wait_in: 1'b0, wait_out: 1'b0, br: BR_NEXT,
                        target: STEP_LOAD};
      STEP_OUT:  cw = '{op: OP_OUT, wait_in: 1'b0, wait_out: 1'b1, br: BR_JUMP,
                        target: STEP_LOAD};
      default:   cw = '{op: OP_LOAD, wait_in: 1'b0, wait_out: 1'b0, br: BR_JUMP,
                        target: STEP_LOAD};
    endcase
    return cw;
  endfunction

endpackage

// File: rtl/core/hds_if.sv
// Handshake interfaces for pose input, command output and register writes.
interface hds_pose_if;
  logic        valid;
  logic        ready;
  logic [31:0] pose_x;
  logic [31:0] pose_y;
  logic [15:0] pose_heading;

  modport source (output valid, output pose_x, output pose_y, output pose_heading,
                  input ready);
  modport sink (input valid, input pose_x, input pose_y, input pose_heading,
                output ready);
endinterface

interface hds_cmd_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_cmd;
  logic [15:0] turn_cmd;
  logic        goal_reached;

  modport source (output valid, output speed_cmd, output turn_cmd, output goal_reached,
                  input ready);
  modport sink (input valid, input speed_cmd, input turn_cmd, input goal_reached,
                output ready);
endinterface

interface hds_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/heading_distance_servo_unit.sv
// Heading and distance servo: microcoded step length, distance total and steering.
//
//   channel  direction  payload
//   pose     in         pose_x, pose_y, pose_heading
//   cmd      out        speed_cmd, turn_cmd, goal_reached
//   cfg      in         index, data (goal_speed, goal_distance, goal_heading)
//
// A pose beat accepted at LOAD passes SQ_A, SQ_B, SUM, the digit-by-digit square root
// loop of DELTA_LIMIT_BITS + 2 steps and ACC before OUT loads the command register;
// the next pose is taken only once the sequencer is back at LOAD.
// One pose is worked on at a time; the next is taken while a command still waits.
// Reset is synchronous and clears the goals, the last pose and the distance total.
// A stalled command beat holds the sequencer at its final step until it is taken.
`include "heading_distance_servo_unit_defines.svh"

module heading_distance_servo_unit
  import hds_pkg::*;
#(
  parameter int unsigned DELTA_LIMIT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  hds_pose_if.sink   pose,
  hds_cmd_if.source  cmd,
  hds_cfg_if.sink    cfg
);

  localparam int unsigned MW    = DELTA_LIMIT_BITS + 1;
  localparam int unsigned PRW   = 2 * MW;
  localparam int unsigned SW    = 2 * DELTA_LIMIT_BITS + 4;
  localparam int unsigned RTW   = DELTA_LIMIT_BITS + 2;
  localparam int unsigned RW    = DELTA_LIMIT_BITS + 6;
  localparam int unsigned ITERS = DELTA_LIMIT_BITS + 2;
  localparam int unsigned CNTW  = $clog2(ITERS + 1);
  localparam logic [32:0] LIM   = 33'd1 << DELTA_LIMIT_BITS;

  pc_t             pc;
  pc_t             pc_next;
  ctrl_t           cw;
  logic [CNTW-1:0] cnt;
  logic [15:0]     goal_speed;
  logic [15:0]     goal_distance;
  logic [15:0]     goal_heading;
  logic [31:0]     prev_x;
  logic [31:0]     prev_y;
  logic [31:0]     travelled;
  logic [MW-1:0]   mag_a;
  logic [MW-1:0]   mag_b;
  logic [15:0]     head;
  logic [PRW-1:0]  prod;
  logic [SW-1:0]   sq;
  logic [RW-1:0]   rem;
  logic [RTW-1:0]  root;
  logic            out_valid;
  logic [15:0]     out_speed;
  logic [15:0]     out_turn;
  logic            out_reached;

  logic            in_take;
  logic            out_free;
  logic            out_load;
  logic            stall;
  logic            cfg_take;
  logic [MW-1:0]   mag_a_next;
  logic [MW-1:0]   mag_b_next;
  logic [RW-1:0]   rem_shift;
  logic [RW-1:0]   trial;
  logic [32:0]     total;
  logic [31:0]     threshold;
  logic            reached;
  logic signed [17:0] err_raw;
  logic signed [17:0] err;
  logic        [17:0] err_mag;
  logic               fast;
  logic [15:0]        turn_next;
  logic [15:0]        speed_next;

  function automatic logic [MW-1:0] clamp_mag(input logic [31:0] p, input logic [31:0] q);
    logic [32:0] d;
    logic [32:0] m;
    d = {p[31], p} - {q[31], q};
    m = d[32] ? (33'd0 - d) : d;
    if (m > LIM) begin
      m = LIM;
    end
    return m[MW-1:0];
  endfunction

  assign cw        = ucode(pc);
  assign in_take   = pose.valid && pose.ready;
  assign out_free  = !out_valid || cmd.ready;
  assign stall     = (cw.wait_in && !in_take) || (cw.wait_out && !out_free);
  assign out_load  = (cw.op == OP_OUT) && out_free;
  assign cfg_take  = cfg.valid && cfg.ready;

  assign pose.ready = cw.wait_in && !rst;
  assign cfg.ready  = 1'b1;

  assign cmd.valid        = out_valid;
  assign cmd.speed_cmd    = out_speed;
  assign cmd.turn_cmd     = out_turn;
  assign cmd.goal_reached = out_reached;

  assign mag_a_next = clamp_mag(pose.pose_x, prev_x);
  assign mag_b_next = clamp_mag(pose.pose_y, prev_y);

  assign rem_shift = {rem[RW-3:0], sq[SW-1:SW-2]};
  assign trial     = {2'b00, root, 2'b01};

  assign total     = {1'b0, travelled} + {{(33 - RTW){1'b0}}, root};
  assign threshold = {16'd0, goal_distance} * MM_TO_UM;
  assign reached   = travelled >= threshold;

  always_comb begin
    err_raw = $signed({2'b00, goal_heading}) - $signed({2'b00, head});
    err     = err_raw;
    if (err_raw > HALF_TURN) begin
      err = err_raw - FULL_TURN;
    end else if (err_raw < -HALF_TURN) begin
      err = err_raw + FULL_TURN;
    end
    err_mag = err[17] ? 18'(-err) : 18'(err);
    fast    = err_mag >= FAST_LIMIT;
    if (fast) begin
      turn_next = err[17] ? 16'(-QUARTER_RATE) : 16'(QUARTER_RATE);
    end else begin
      turn_next = err[15:0];
    end
    speed_next = (!fast && !reached) ? goal_speed : 16'd0;
  end

  always_comb begin
    pc_next = pc;
    if (!stall) begin
      unique case (cw.br)
        BR_NEXT: pc_next = pc + 3'd1;
        BR_LOOP: pc_next = (cnt != CNTW'(1)) ? cw.target : pc + 3'd1;
        BR_JUMP: pc_next = cw.target;
        default: pc_next = STEP_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= STEP_LOAD;
      cnt           <= '0;
      out_valid     <= 1'b0;
      goal_speed    <= '0;
      goal_distance <= '0;
      goal_heading  <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      travelled     <= '0;
    end else begin
      pc <= pc_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
      if (in_take) begin
        prev_x <= pose.pose_x;
        prev_y <= pose.pose_y;
      end
      if (cw.op == OP_SQ_A) begin
        cnt <= CNTW'(ITERS);
      end else if (cw.op == OP_ROOT) begin
        cnt <= cnt - CNTW'(1);
      end
      if (cfg_take) begin
        unique case (cfg.index)
          REG_GOAL_SPEED: begin
            goal_speed <= cfg.data;
            travelled  <= '0;
          end
          REG_GOAL_DISTANCE: begin
            goal_distance <= cfg.data;
            travelled     <= '0;
          end
          REG_GOAL_HEADING: begin
            goal_heading <= cfg.data;
            travelled    <= '0;
          end
          default: begin
          end
        endcase
      end else if (cw.op == OP_ACC) begin
        travelled <= total[32] ? 32'hFFFF_FFFF : total[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_LOAD: begin
        if (in_take) begin
          mag_a <= mag_a_next;
          mag_b <= mag_b_next;
          head  <= pose.pose_heading;
        end
      end
      OP_SQ_A: prod <= mag_a * mag_a;
      OP_SQ_B: begin
        prod <= mag_b * mag_b;
        sq   <= {{(SW - PRW){1'b0}}, prod};
      end
      OP_SUM: begin
        sq   <= sq + {{(SW - PRW){1'b0}}, prod};
        rem  <= '0;
        root <= '0;
      end
      OP_ROOT: begin
        sq <= {sq[SW-3:0], 2'b00};
        if (rem_shift >= trial) begin
          rem  <= rem_shift - trial;
          root <= {root[RTW-2:0], 1'b1};
        end else begin
          rem  <= rem_shift;
          root <= {root[RTW-2:0], 1'b0};
        end
      end
      OP_OUT: begin
        if (out_load) begin
          out_speed   <= speed_next;
          out_turn    <= turn_next;
          out_reached <= reached;
        end
      end
      default: begin
      end
    endcase
  end

  `HDS_ASSERT_NEXT(a_take_starts_work, in_take, pc == STEP_SQ_A)
  `HDS_ASSERT_NEXT(a_root_loop_exit, (pc == STEP_ROOT) && (cnt == CNTW'(1)), pc == STEP_ACC)
  `HDS_ASSERT_NEXT(a_total_grows, !cfg_take, travelled >= $past(travelled))
  `HDS_ASSERT_NOW(a_load_free_slot, out_load, !out_valid || cmd.ready)

endmodule

// File: verif/heading_distance_servo_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the heading and distance servo: random poses, goals and stalls.
module heading_distance_servo_unit_test
  import hds_pkg::*;
();

  localparam int DELTA_BITS = 24;
  localparam int RUN_LIMIT = 600000;
  localparam int HALF_REV = 32768;
  localparam int FULL_REV = 65536;
  localparam int SPIN_LIMIT = 3277;
  localparam logic signed [15:0] SPIN_RATE = 16'sd16384;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int TRIP_PHASES = 14;
  localparam int TRIP_LENGTH = 100;
  localparam int WRAP_STEPS = 200;

  typedef struct {
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [15:0] pose_heading;
  } pose_t;

  typedef struct {
    logic [15:0] speed_cmd;
    logic [15:0] turn_cmd;
    logic        goal_reached;
  } servo_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hds_pose_if pose_ch ();
  hds_cmd_if  cmd_ch ();
  hds_cfg_if  cfg_ch ();

  heading_distance_servo_unit #(.DELTA_LIMIT_BITS(DELTA_BITS)) uut (
    .clk (clk),
    .rst (rst),
    .pose(pose_ch),
    .cmd (cmd_ch),
    .cfg (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [15:0]        want_speed = '0;
  logic [15:0]        want_distance = '0;
  logic [15:0]        want_heading = '0;
  logic signed [31:0] last_x = '0;
  logic signed [31:0] last_y = '0;
  logic [31:0]        travelled_um = '0;

  pose_t      pose_q[$];
  servo_cmd_t cmd_q[$];
  pose_t      cur_pose;
  logic [31:0] gen_x = '0;
  logic [31:0] gen_y = '0;

  bit pose_pending = 1'b0;
  bit pose_taken = 1'b0;
  bit cmd_taken = 1'b0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit recv_hold = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic servo_cmd_t predict_cmd(input pose_t p);
    longint      lim;
    longint      dx;
    longint      dy;
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] cand;
    logic [32:0] total;
    int          err;
    int          mag;
    servo_cmd_t  c;
    lim = longint'(1) << DELTA_BITS;
    dx = longint'($signed(p.pose_x)) - longint'(last_x);
    dy = longint'($signed(p.pose_y)) - longint'(last_y);
    if (dx > lim) dx = lim;
    else if (dx < -lim) dx = -lim;
    if (dy > lim) dy = lim;
    else if (dy < -lim) dy = -lim;
    sq = dx * dx + dy * dy;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    total = {1'b0, travelled_um} + root[32:0];
    travelled_um = total[32] ? 32'hFFFF_FFFF : total[31:0];
    last_x = p.pose_x;
    last_y = p.pose_y;
    err = int'(want_heading) - int'(p.pose_heading);
    if (err > HALF_REV) err -= FULL_REV;
    else if (err < -HALF_REV) err += FULL_REV;
    mag = (err < 0) ? -err : err;
    c.speed_cmd = '0;
    if (mag >= SPIN_LIMIT) begin
      c.turn_cmd = (err < 0) ? -SPIN_RATE : SPIN_RATE;
    end else begin
      c.turn_cmd = err[15:0];
      c.speed_cmd = want_speed;
    end
    c.goal_reached = {32'd0, travelled_um} >= 64'(want_distance) * 64'd1000;
    if (c.goal_reached) c.speed_cmd = '0;
    return c;
  endfunction

  function automatic void apply_goal(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      REG_GOAL_SPEED:    want_speed = val;
      REG_GOAL_DISTANCE: want_distance = val;
      REG_GOAL_HEADING:  want_heading = val;
      default: ;
    endcase
    if (idx != REG_SPARE) travelled_um = '0;
  endfunction

  function automatic void flag_mismatch(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    $display("%0t: %s expected %h actual %h", $time, field, want, got);
    mismatches++;
  endfunction

  function automatic void queue_pose(input logic [31:0] x, input logic [31:0] y,
                                     input logic [15:0] h);
    pose_t p;
    p.pose_x = x;
    p.pose_y = y;
    p.pose_heading = h;
    pose_q.push_back(p);
    gen_x = x;
    gen_y = y;
  endfunction

  function automatic logic [31:0] draw_step(input bit rough);
    logic [31:0] mag;
    int          pick;
    pick = $urandom_range(0, 9);
    if (rough && pick < 3) mag = (32'd1 << DELTA_BITS) + $urandom_range(0, 2) - 1;
    else if (rough && pick < 6) mag = $urandom_range(0, 1 << (DELTA_BITS + 1));
    else mag = $urandom_range(0, 1 << $urandom_range(4, 17));
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  function automatic void queue_trip(input int count, input bit rough);
    logic [15:0] h;
    for (int i = 0; i < count; i++) begin
      if (rough && $urandom_range(0, 9) == 0) begin
        queue_pose($urandom, $urandom, 16'($urandom));
      end else begin
        if ($urandom_range(0, 9) < 7)
          h = want_heading + 16'($urandom_range(0, 8000)) - 16'd4000;
        else h = 16'($urandom);
        queue_pose(gen_x + draw_step(rough), gen_y + draw_step(rough), h);
      end
    end
  endfunction

  function automatic logic [15:0] draw_goal(input int span);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, span));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_goal(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_goal(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pose_q.size() != 0 || pose_pending || cmd_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && pose_ch.valid && pose_ch.ready) begin
      cmd_q.push_back(predict_cmd(cur_pose));
      pose_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pose_ch.valid <= 1'b0;
    end else begin
      if (pose_taken) begin
        pose_taken = 1'b0;
        pose_pending = 1'b0;
      end
      if (!pose_pending) begin
        if (send_gap > 0 || pose_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          pose_ch.valid <= 1'b0;
        end else begin
          cur_pose = pose_q.pop_front();
          pose_ch.pose_x <= cur_pose.pose_x;
          pose_ch.pose_y <= cur_pose.pose_y;
          pose_ch.pose_heading <= cur_pose.pose_heading;
          pose_ch.valid <= 1'b1;
          pose_pending = 1'b1;
          send_gap = calm ? 0 : $urandom_range(0, 9);
        end
      end
    end
  end

  always @(posedge clk) begin
    servo_cmd_t want;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      cmd_taken = 1'b1;
      if (cmd_q.size() == 0) begin
        flag_mismatch("unexpected beat, speed_cmd", '0, cmd_ch.speed_cmd);
      end else begin
        want = cmd_q.pop_front();
        if (cmd_ch.speed_cmd !== want.speed_cmd)
          flag_mismatch("speed_cmd", want.speed_cmd, cmd_ch.speed_cmd);
        if (cmd_ch.turn_cmd !== want.turn_cmd)
          flag_mismatch("turn_cmd", want.turn_cmd, cmd_ch.turn_cmd);
        if (cmd_ch.goal_reached !== want.goal_reached)
          flag_mismatch("goal_reached", want.goal_reached, cmd_ch.goal_reached);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.ready <= 1'b0;
    end else begin
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        recv_gap = calm ? 0 : $urandom_range(0, 9);
      end
      if (recv_hold) begin
        cmd_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        cmd_ch.ready <= 1'b0;
      end else begin
        cmd_ch.ready <= 1'b1;
      end
    end
  end

  // The block holds one pose and one finished command, so this stall backs up the pose side.
  initial begin
    wait (hold_go);
    @(negedge clk);
    recv_hold <= 1'b1;
    repeat (300) @(negedge clk);
    recv_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_GOAL_SPEED;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_goal(REG_GOAL_SPEED, 16'd300);
    write_goal(REG_GOAL_DISTANCE, 16'hFFFF);
    write_goal(REG_GOAL_HEADING, 16'h4000);
    queue_pose(32'd3000, 32'd4000, 16'h4000);
    queue_pose(32'd3000, 32'd4000, 16'h4000 + 16'd3276);
    queue_pose(32'd3000, 32'd4000, 16'h4000 - 16'd3276);
    queue_pose(32'd3000, 32'd4000, 16'h4000 - 16'd3277);
    queue_pose(32'd3000, 32'd4000, 16'h4000 + 16'd3277);
    queue_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'hC000);
    queue_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
    queue_pose(32'h8000_0000 + (32'd1 << DELTA_BITS),
               32'h7FFF_FFFF - (32'd1 << DELTA_BITS) - 32'd1, 16'hFFFF);
    queue_pose(32'd0, 32'd0, 16'h4000);
    wait_idle();
    write_goal(REG_GOAL_HEADING, 16'hC000);
    queue_pose(32'd0, 32'd0, 16'h4000);
    queue_pose(32'd0, 32'd0, 16'hFFFF);
    wait_idle();
    write_goal(REG_GOAL_HEADING, 16'hFFFF);
    queue_pose(32'd0, 32'd0, 16'h0000);
    wait_idle();
    write_goal(REG_GOAL_HEADING, 16'h0000);
    queue_pose(32'd0, 32'd0, 16'hFFFF);
    wait_idle();
    write_goal(REG_GOAL_DISTANCE, 16'd0);
    queue_pose(32'd5, 32'd5, 16'h0000);
    wait_idle();
    write_goal(REG_GOAL_DISTANCE, 16'd10);
    queue_pose(32'd5, 32'd12005, 16'h0000);
    wait_idle();
    write_goal(REG_SPARE, 16'hFFFF);
    queue_pose(32'd5, 32'd12005, 16'h0010);
    wait_idle();

    // Alternating full-range jumps drive the distance total into saturation.
    write_goal(REG_GOAL_DISTANCE, 16'hFFFF);
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (i % 2 == 0) queue_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'($urandom));
      else queue_pose(32'h8000_0000, 32'h8000_0000, 16'($urandom));
    end
    wait_idle();

    for (int p = 0; p < TRIP_PHASES; p++) begin
      calm = (p % 4 == 1);
      if (p == 0) begin
        write_goal(REG_GOAL_SPEED, 16'hFFFF);
        write_goal(REG_GOAL_DISTANCE, 16'hFFFF);
        write_goal(REG_GOAL_HEADING, 16'hFFFF);
      end else if (p == 1) begin
        write_goal(REG_GOAL_SPEED, 16'h0000);
        write_goal(REG_GOAL_DISTANCE, 16'h0000);
        write_goal(REG_GOAL_HEADING, 16'h0000);
      end else begin
        write_goal(REG_GOAL_SPEED, draw_goal(2000));
        write_goal(REG_GOAL_DISTANCE, draw_goal(500));
        write_goal(REG_GOAL_HEADING, draw_goal(65535));
      end
      if (p % 5 == 3) write_goal(REG_SPARE, 16'($urandom));
      queue_trip(TRIP_LENGTH, p % 3 == 2);
      if (p == 3) hold_go = 1'b1;
      wait_idle();
    end

    calm = 1'b0;
    repeat (DELTA_BITS + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: heading_distance_servo_unit.f
+incdir+rtl/core
rtl/core/hds_pkg.sv
rtl/core/hds_if.sv
rtl/core/heading_distance_servo_unit.sv
verif/heading_distance_servo_unit_test.sv
